// ----- hw/rtl/fszm_pkg.sv -----
package fszm_pkg;

    localparam int VAL_W            = 64;
    localparam int PCT_W            = 7;
    // room for 100 * 2^64 and for 2^64 * 127
    localparam int PROD_W           = VAL_W + 8;
    localparam int NUM_VOL          = 3;
    localparam int IN_TDATA_W       = 2 * NUM_VOL * VAL_W;
    localparam int IN_TUSER_W       = 2;
    localparam int OUT_TDATA_W      = 8;
    localparam logic [PCT_W-1:0] PCT_RESET = 7'd5;
    localparam int REPORT_LIMIT_DEF = 12;

    typedef enum logic [1:0] {
        ZONE_GREEN  = 2'd0,
        ZONE_YELLOW = 2'd1,
        ZONE_RED    = 2'd2
    } t_zone;

    typedef struct packed {
        logic yel;
        logic red;
    } t_flags;

    typedef struct packed {
        logic  warn_red;
        logic  warn_yellow;
        t_zone zone;
    } t_result;

endpackage

// ----- hw/rtl/fszm_volume_check.sv -----
module fszm_volume_check (
    input  logic                          i_en,
    input  logic [fszm_pkg::VAL_W-1:0]    i_avail,
    input  logic [fszm_pkg::VAL_W-1:0]    i_total,
    input  logic [fszm_pkg::PCT_W-1:0]    i_pct,
    output fszm_pkg::t_flags              o_flags
);

    // avail < floor(total*pct/100)      <=> 100*(avail+1)        <= total*pct
    // avail < 2*floor(total*pct/100)    <=> 100*((avail>>1)+1)   <= total*pct
    logic [fszm_pkg::PROD_W-1:0] w_prod;
    logic [fszm_pkg::PROD_W-1:0] w_red_base;
    logic [fszm_pkg::PROD_W-1:0] w_yel_base;
    logic [fszm_pkg::PROD_W-1:0] w_red_lhs;
    logic [fszm_pkg::PROD_W-1:0] w_yel_lhs;

    assign w_prod     = fszm_pkg::PROD_W'(i_total) * fszm_pkg::PROD_W'(i_pct);
    assign w_red_base = fszm_pkg::PROD_W'(i_avail) + fszm_pkg::PROD_W'(1);
    assign w_yel_base = fszm_pkg::PROD_W'(i_avail >> 1) + fszm_pkg::PROD_W'(1);

    // times 100 = 64 + 32 + 4
    assign w_red_lhs = (w_red_base << 6) + (w_red_base << 5) + (w_red_base << 2);
    assign w_yel_lhs = (w_yel_base << 6) + (w_yel_base << 5) + (w_yel_base << 2);

    assign o_flags.red = i_en && (w_red_lhs <= w_prod);
    assign o_flags.yel = i_en && (w_yel_lhs <= w_prod);

endmodule

// ----- hw/rtl/fszm_zone_fsm.sv -----
module fszm_zone_fsm #(
    parameter int REPORT_LIMIT = fszm_pkg::REPORT_LIMIT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  fszm_pkg::t_flags    i_flags,
    output fszm_pkg::t_result   o_result
);

    localparam logic [fszm_pkg::VAL_W-1:0] LIMIT = fszm_pkg::VAL_W'(REPORT_LIMIT);

    fszm_pkg::t_zone              r_zone, n_zone;
    logic [fszm_pkg::VAL_W-1:0]   r_poll, n_poll;
    logic [fszm_pkg::VAL_W-1:0]   r_last_red, n_last_red;
    logic [fszm_pkg::VAL_W-1:0]   r_last_yel, n_last_yel;
    logic                         w_may_red;
    logic                         w_may_yel;
    logic                         w_warn_red;
    logic                         w_warn_yel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone     <= fszm_pkg::ZONE_GREEN;
            r_poll     <= '0;
            r_last_red <= '0;
            r_last_yel <= '0;
        end else if (i_step) begin
            r_zone     <= n_zone;
            r_poll     <= n_poll;
            r_last_red <= n_last_red;
            r_last_yel <= n_last_yel;
        end
    end

    assign n_poll = r_poll + fszm_pkg::VAL_W'(1);

    // age is modulo 2^64; early polls always report
    assign w_may_red = ((n_poll - r_last_red) > LIMIT) || (n_poll < LIMIT);
    assign w_may_yel = ((n_poll - r_last_yel) > LIMIT) || (n_poll < LIMIT);

    always_comb begin
        n_zone     = r_zone;
        n_last_red = r_last_red;
        n_last_yel = r_last_yel;
        w_warn_red = 1'b0;
        w_warn_yel = 1'b0;
        case (r_zone)
            fszm_pkg::ZONE_RED: begin
                if (!i_flags.red) begin
                    n_zone = i_flags.yel ? fszm_pkg::ZONE_YELLOW : fszm_pkg::ZONE_GREEN;
                end
            end
            fszm_pkg::ZONE_YELLOW: begin
                if (i_flags.red) begin
                    w_warn_red = w_may_red;
                    n_zone     = fszm_pkg::ZONE_RED;
                    n_last_red = n_poll;
                end else if (!i_flags.yel) begin
                    n_zone = fszm_pkg::ZONE_GREEN;
                end
            end
            default: begin
                if (i_flags.red) begin
                    w_warn_red = w_may_red;
                    n_zone     = fszm_pkg::ZONE_RED;
                    n_last_red = n_poll;
                end else if (i_flags.yel) begin
                    w_warn_yel = w_may_yel;
                    n_zone     = fszm_pkg::ZONE_YELLOW;
                    n_last_yel = n_poll;
                end else begin
                    n_zone = fszm_pkg::ZONE_GREEN;
                end
            end
        endcase
    end

    assign o_result.zone        = n_zone;
    assign o_result.warn_yellow = w_warn_yel;
    assign o_result.warn_red    = w_warn_red;

endmodule

// ----- hw/rtl/free_space_zone_monitor_unit.sv -----
// Path: a poll word passes the input register, the flag register and the result register
//   before its result word appears on m_axis.
// Throughput: one poll word per cycle unless m_axis stalls; each stage holds only while the
//   stage after it is full and stalled, so a new word is taken while a finished result waits.
// Reset: synchronous, active low; clears all valid bits, zone to green, poll count and
//   last-entry marks to zero, and the red zone percent register to 5.
module free_space_zone_monitor_unit #(
    parameter int REPORT_LIMIT = fszm_pkg::REPORT_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,

    // red zone percent register
    input  logic                              i_cfg_we,
    input  logic [fszm_pkg::PCT_W-1:0]        i_cfg_wdata,

    // poll words in
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [63:0] home_avail, [127:64] home_total, [191:128] data_avail,
    // [255:192] data_total, [319:256] log_avail, [383:320] log_total
    input  logic [fszm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // [0] data_separate, [1] log_separate
    input  logic [fszm_pkg::IN_TUSER_W-1:0]   s_axis_tuser,

    // zone words out
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [1:0] zone, [2] warn_yellow, [3] warn_red, [7:4] zero
    output logic [fszm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    localparam int W = fszm_pkg::VAL_W;

    // configuration
    logic [fszm_pkg::PCT_W-1:0]        r_pct;

    // stage 0: input register
    logic                              r_s0_valid;
    logic [fszm_pkg::IN_TDATA_W-1:0]   r_s0_data;
    logic [fszm_pkg::IN_TUSER_W-1:0]   r_s0_user;

    // stage 1: per-poll zone flags
    logic                              r_s1_valid;
    fszm_pkg::t_flags                  r_s1_flags;

    // stage 2: result register
    logic                              r_out_valid;
    fszm_pkg::t_result                 r_out;

    fszm_pkg::t_flags                  w_home_flags, w_data_flags, w_log_flags;
    fszm_pkg::t_flags                  w_flags;
    fszm_pkg::t_result                 w_result;

    logic w_out_free;   // result register can take a word this cycle
    logic w_s1_free;
    logic w_s0_free;
    logic w_in_acc;
    logic w_s0_move;
    logic w_s1_move;

    // ---------------------------------------------------------------------
    // Flow control: each stage advances when the next one is empty or
    // emptying, so bubbles are squeezed out under back pressure.
    // ---------------------------------------------------------------------
    assign w_out_free = !r_out_valid || m_axis_tready;
    assign w_s1_free  = !r_s1_valid  || w_out_free;
    assign w_s0_free  = !r_s0_valid  || w_s1_free;

    assign w_in_acc   = s_axis_tvalid && w_s0_free;
    assign w_s0_move  = r_s0_valid && w_s1_free;
    assign w_s1_move  = r_s1_valid && w_out_free;

    assign s_axis_tready = w_s0_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pct <= fszm_pkg::PCT_RESET;
        end else if (i_cfg_we) begin
            r_pct <= i_cfg_wdata;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid  <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s0_free) begin
                r_s0_valid <= s_axis_tvalid;
            end
            if (w_s1_free) begin
                r_s1_valid <= r_s0_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s0_data <= s_axis_tdata;
            r_s0_user <= s_axis_tuser;
        end
        if (w_s0_move) begin
            r_s1_flags <= w_flags;
        end
        if (w_s1_move) begin
            r_out <= w_result;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 0 -> 1: compare each volume against its red zone and twice it.
    // Home is always checked; data and log only when flagged separate.
    // ---------------------------------------------------------------------
    fszm_volume_check u_home (
        .i_en    (1'b1),
        .i_avail (r_s0_data[0*W +: W]),
        .i_total (r_s0_data[1*W +: W]),
        .i_pct   (r_pct),
        .o_flags (w_home_flags)
    );

    fszm_volume_check u_data (
        .i_en    (r_s0_user[0]),
        .i_avail (r_s0_data[2*W +: W]),
        .i_total (r_s0_data[3*W +: W]),
        .i_pct   (r_pct),
        .o_flags (w_data_flags)
    );

    fszm_volume_check u_log (
        .i_en    (r_s0_user[1]),
        .i_avail (r_s0_data[4*W +: W]),
        .i_total (r_s0_data[5*W +: W]),
        .i_pct   (r_pct),
        .o_flags (w_log_flags)
    );

    assign w_flags.red = w_home_flags.red || w_data_flags.red || w_log_flags.red;
    assign w_flags.yel = w_home_flags.yel || w_data_flags.yel || w_log_flags.yel;

    // ---------------------------------------------------------------------
    // Stage 1 -> 2: zone state machine steps once per word leaving stage 1.
    // ---------------------------------------------------------------------
    fszm_zone_fsm #(
        .REPORT_LIMIT (REPORT_LIMIT)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_s1_move),
        .i_flags  (r_s1_flags),
        .o_result (w_result)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.warn_red, r_out.warn_yellow, r_out.zone};

endmodule

// ----- hw/rtl/fszm_checker.sv -----
module fszm_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic [fszm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // nothing comes out right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_red_warn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[3] |-> m_axis_tdata[1:0] == fszm_pkg::ZONE_RED)
        else $error("red warning outside red zone");

    a_yel_warn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2] |-> m_axis_tdata[1:0] == fszm_pkg::ZONE_YELLOW)
        else $error("yellow warning outside yellow zone");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:4] == 4'b0000)
        else $error("pad bits set in result word");

endmodule

bind free_space_zone_monitor_unit fszm_checker u_fszm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
